// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules (clock i_clk, reset i_rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/sfrd_pkg.sv
// Package for the serial frame receive deframer: register indexes, resets, phase type.
package sfrd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] CFG_SLOT_CAPACITY = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RST_SYNC_FIRST    = 8'd170;
    localparam logic [7:0] RST_SYNC_SECOND   = 8'd85;
    localparam logic [7:0] RST_SLOT_CAPACITY = 8'd64;

    // Item opcodes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_SYNC0   = 5'b00001,
        PH_SYNC1   = 5'b00010,
        PH_ADDR    = 5'b00100,
        PH_LEN     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

endpackage

// File: rtl/core/serial_frame_receive_deframer.sv
// Serial frame receive deframer: sync/address/length parser with slot-occupancy tracking.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer: a received
// byte (i_op = 0, i_rx_byte) or a slot release (i_op = 1). Frames are first sync
// byte, second sync byte, address, length, payload. Every item gives exactly one
// result on the output channel (o_out_valid / i_out_stall): payload slot writes,
// frame delivery, too-long flag, or busy-drop flag, all zero on a release.
// The result of an item is registered at the edge that accepts it. One item is
// taken per cycle while the result register can drain; parser state update and result
// register are a single stage, so the only limit is the output register draining.
// When the receiver stalls, the result register holds and o_in_stall rises only
// if that register is full and stalled, so a new item is taken in the same cycle
// the old result leaves. The configuration port (i_cfg_we, i_cfg_index, i_cfg_data)
// writes sync bytes and slot capacity; write it only while the block is idle.
// Synchronous reset clears the parser to hunting for the first sync byte, frees the
// slot, empties the result register and restores the register defaults.
`include "assert_macros.svh"

module serial_frame_receive_deframer
    import sfrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_store_valid,
    output logic [7:0] o_store_index,
    output logic [7:0] o_store_data,
    output logic       o_frame_done,
    output logic [7:0] o_frame_address,
    output logic [7:0] o_frame_length,
    output logic       o_frame_too_long,
    output logic       o_byte_dropped_busy
);

    // configuration registers
    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_slot_capacity;

    // parser state
    t_phase     r_phase,         n_phase;
    logic [7:0] r_held_address,  n_held_address;
    logic [7:0] r_held_length,   n_held_length;
    logic [7:0] r_payload_count, n_payload_count;
    logic       r_slot_occupied, n_slot_occupied;

    // result register
    logic       r_out_valid;
    logic       r_store_valid,   n_store_valid;
    logic [7:0] r_store_index,   n_store_index;
    logic [7:0] r_store_data,    n_store_data;
    logic       r_frame_done,    n_frame_done;
    logic [7:0] r_frame_address, n_frame_address;
    logic [7:0] r_frame_length,  n_frame_length;
    logic       r_frame_too_long, n_frame_too_long;
    logic       r_byte_dropped,  n_byte_dropped;

    logic       w_accept;
    logic [7:0] w_count_inc;

    // stall input only when the result register is full and cannot drain
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_count_inc = r_payload_count + 8'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first    <= RST_SYNC_FIRST;
            r_sync_second   <= RST_SYNC_SECOND;
            r_slot_capacity <= RST_SLOT_CAPACITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:    r_sync_first    <= i_cfg_data;
                CFG_SYNC_SECOND:   r_sync_second   <= i_cfg_data;
                CFG_SLOT_CAPACITY: r_slot_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser next state and result for the item on the input
    always_comb begin
        n_phase          = r_phase;
        n_held_address   = r_held_address;
        n_held_length    = r_held_length;
        n_payload_count  = r_payload_count;
        n_slot_occupied  = r_slot_occupied;
        n_store_valid    = 1'b0;
        n_store_index    = 8'd0;
        n_store_data     = 8'd0;
        n_frame_done     = 1'b0;
        n_frame_address  = 8'd0;
        n_frame_length   = 8'd0;
        n_frame_too_long = 1'b0;
        n_byte_dropped   = 1'b0;

        if (i_op == OP_RELEASE) begin
            n_slot_occupied = 1'b0;
        end else if (r_slot_occupied) begin
            // slot busy: drop the byte and resync
            n_phase        = PH_SYNC0;
            n_byte_dropped = 1'b1;
        end else begin
            case (r_phase)
                PH_SYNC1: begin
                    n_phase = (i_rx_byte == r_sync_second) ? PH_ADDR : PH_SYNC0;
                end
                PH_ADDR: begin
                    n_held_address = i_rx_byte;
                    n_phase        = PH_LEN;
                end
                PH_LEN: begin
                    n_held_length   = i_rx_byte;
                    n_payload_count = 8'd0;
                    if (i_rx_byte == 8'd0) begin
                        // empty frame delivers at once
                        n_frame_done    = 1'b1;
                        n_frame_address = r_held_address;
                        n_slot_occupied = 1'b1;
                        n_phase         = PH_SYNC0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_payload_count < r_slot_capacity) begin
                        n_store_valid = 1'b1;
                        n_store_index = r_payload_count;
                        n_store_data  = i_rx_byte;
                    end
                    n_payload_count = w_count_inc;
                    if (w_count_inc == r_held_length) begin
                        if (r_held_length <= r_slot_capacity) begin
                            n_frame_done    = 1'b1;
                            n_frame_address = r_held_address;
                            n_frame_length  = r_held_length;
                            n_slot_occupied = 1'b1;
                        end else begin
                            n_frame_too_long = 1'b1;
                        end
                        n_phase = PH_SYNC0;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == r_sync_first) ? PH_SYNC1 : PH_SYNC0;
                end
            endcase
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SYNC0;
            r_held_address  <= 8'd0;
            r_held_length   <= 8'd0;
            r_payload_count <= 8'd0;
            r_slot_occupied <= 1'b0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_held_address  <= n_held_address;
            r_held_length   <= n_held_length;
            r_payload_count <= n_payload_count;
            r_slot_occupied <= n_slot_occupied;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store_valid    <= n_store_valid;
            r_store_index    <= n_store_index;
            r_store_data     <= n_store_data;
            r_frame_done     <= n_frame_done;
            r_frame_address  <= n_frame_address;
            r_frame_length   <= n_frame_length;
            r_frame_too_long <= n_frame_too_long;
            r_byte_dropped   <= n_byte_dropped;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_store_valid       = r_store_valid;
    assign o_store_index       = r_store_index;
    assign o_store_data        = r_store_data;
    assign o_frame_done        = r_frame_done;
    assign o_frame_address     = r_frame_address;
    assign o_frame_length      = r_frame_length;
    assign o_frame_too_long    = r_frame_too_long;
    assign o_byte_dropped_busy = r_byte_dropped;

    // a frame cannot be both delivered and rejected
    `ASSERT_SAME(a_done_xor_long, r_out_valid, !(r_frame_done && r_frame_too_long))
    // a byte that meets an occupied slot is reported as dropped
    `ASSERT_NEXT(a_busy_drop, w_accept && (i_op == OP_BYTE) && r_slot_occupied, r_byte_dropped)
    // a delivery leaves the slot occupied
    `ASSERT_NEXT(a_done_occupies, w_accept && n_frame_done, r_slot_occupied)
    // payload phase is only entered with a nonzero length
    `ASSERT_SAME(a_payload_len, r_phase == PH_PAYLOAD, r_held_length != 8'd0)

endmodule

// File: tb/serial_frame_receive_deframer_tb.sv
// Testbench for the serial frame receive deframer: directed and random byte streams.
`timescale 1ns / 100ps

module serial_frame_receive_deframer_tb;
    import sfrd_pkg::*;

    // One deframer result, the same fields as the output port
    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_data;
        logic       frame_done;
        logic [7:0] frame_address;
        logic [7:0] frame_length;
        logic       frame_too_long;
        logic       byte_dropped_busy;
    } t_deframe_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_op;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_store_valid;
    logic [7:0] o_store_index;
    logic [7:0] o_store_data;
    logic       o_frame_done;
    logic [7:0] o_frame_address;
    logic [7:0] o_frame_length;
    logic       o_frame_too_long;
    logic       o_byte_dropped_busy;

    serial_frame_receive_deframer dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_store_valid       (o_store_valid),
        .o_store_index       (o_store_index),
        .o_store_data        (o_store_data),
        .o_frame_done        (o_frame_done),
        .o_frame_address     (o_frame_address),
        .o_frame_length      (o_frame_length),
        .o_frame_too_long    (o_frame_too_long),
        .o_byte_dropped_busy (o_byte_dropped_busy)
    );

    // Model copy of the registers and parser state
    logic [7:0] cfg_sync_lead;
    logic [7:0] cfg_sync_trail;
    logic [7:0] cfg_capacity;
    t_phase     hunt_phase;
    logic [7:0] frame_addr_q;
    logic [7:0] frame_len_q;
    logic [7:0] byte_pos;
    logic       slot_full;

    t_deframe_result expected_results[$];
    int error_count;
    int result_count;
    int sent_count;

    // Pacing controls shared by the sender, the receiver and the tests
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int hold_len;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Hard limit on run time
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    // Next result for one transfer; updates the model state
    function automatic t_deframe_result predict_deframe(input logic op, input logic [7:0] b);
        t_deframe_result r;
        r = '0;
        if (op == OP_RELEASE) begin
            slot_full = 1'b0;
        end else if (slot_full) begin
            hunt_phase = PH_SYNC0;
            r.byte_dropped_busy = 1'b1;
        end else begin
            case (hunt_phase)
                PH_SYNC1: begin
                    hunt_phase = (b == cfg_sync_trail) ? PH_ADDR : PH_SYNC0;
                end
                PH_ADDR: begin
                    frame_addr_q = b;
                    hunt_phase = PH_LEN;
                end
                PH_LEN: begin
                    frame_len_q = b;
                    byte_pos = 8'd0;
                    if (b == 8'd0) begin
                        // empty frame delivers at once
                        r.frame_done = 1'b1;
                        r.frame_address = frame_addr_q;
                        slot_full = 1'b1;
                        hunt_phase = PH_SYNC0;
                    end else begin
                        hunt_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (byte_pos < cfg_capacity) begin
                        r.store_valid = 1'b1;
                        r.store_index = byte_pos;
                        r.store_data = b;
                    end
                    byte_pos = byte_pos + 8'd1;
                    if (byte_pos == frame_len_q) begin
                        if (frame_len_q <= cfg_capacity) begin
                            r.frame_done = 1'b1;
                            r.frame_address = frame_addr_q;
                            r.frame_length = frame_len_q;
                            slot_full = 1'b1;
                        end else begin
                            r.frame_too_long = 1'b1;
                        end
                        hunt_phase = PH_SYNC0;
                    end
                end
                default: begin
                    hunt_phase = (b == cfg_sync_lead) ? PH_SYNC1 : PH_SYNC0;
                end
            endcase
        end
        return r;
    endfunction

    // Offer one item, wait for its transfer, then record the expected result
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = op;
        i_rx_byte = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_deframe(op, b));
        sent_count++;
    endtask

    // Stop offering and let every outstanding result drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write, only called while idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SYNC_FIRST:    cfg_sync_lead = val;
            CFG_SYNC_SECOND:   cfg_sync_trail = val;
            CFG_SLOT_CAPACITY: cfg_capacity = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] lead, input logic [7:0] trail,
                              input logic [7:0] cap);
        wait_idle();
        write_reg(CFG_SYNC_FIRST, lead);
        write_reg(CFG_SYNC_SECOND, trail);
        write_reg(CFG_SLOT_CAPACITY, cap);
    endtask

    // Whole frame with the current sync bytes; payload may carry stray releases
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
                              input bit rand_rel);
        send_item(OP_BYTE, cfg_sync_lead);
        send_item(OP_BYTE, cfg_sync_trail);
        send_item(OP_BYTE, addr);
        send_item(OP_BYTE, len);
        for (int k = 0; k < len; k++) begin
            if (rand_rel && $urandom_range(0, 19) == 0)
                send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
            send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Frame at default settings, bus extremes in the payload
    task automatic test_default_frame();
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'h07);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        // slot now occupied: next byte is dropped
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_RELEASE, 8'h00);
        // release of a free slot changes nothing
        send_item(OP_RELEASE, 8'hFF);
    endtask

    // Wrong second sync, empty frame, too long and zero capacity
    task automatic test_special_cases();
        // the mismatching second byte must not be taken as a new first sync byte
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, 8'h55);
        // empty frame
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_RELEASE, 8'h00);
        // capacity one, frame of two: one store then too long
        set_config(8'h00, 8'hFF, 8'd1);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h10);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, 8'h11);
        send_item(OP_BYTE, 8'h22);
        // capacity zero: nothing stored, too long
        set_config(8'h00, 8'hFF, 8'd0);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h33);
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        set_config(8'hAA, 8'h55, 8'd64);
        tx_idle_on = 1'b0;
        hold_len = 40;
        hold_req = 1'b1;
        send_frame(8'h5A, 8'd8, 1'b0);
        send_item(OP_RELEASE, 8'h00);
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    // Random stream at one setting: mostly clean frames, some noise and broken ones
    task automatic random_phase(input int n_items, input int max_len);
        int start;
        int r;
        int cut;
        logic [7:0] len;
        start = sent_count;
        while (sent_count - start < n_items) begin
            r = $urandom_range(0, 99);
            if (slot_full) begin
                if (r < 85) send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
                else send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end else if (r < 70) begin
                case ($urandom_range(0, 9))
                    0: len = 8'd0;
                    1: len = 8'((cfg_capacity <= max_len) ? cfg_capacity : max_len);
                    2: len = 8'((cfg_capacity < max_len) ? cfg_capacity + 8'd1 : max_len);
                    3: len = 8'($urandom_range(0, max_len));
                    default: len = 8'($urandom_range(1, 6));
                endcase
                send_frame(8'($urandom_range(0, 255)), len, 1'b1);
            end else if (r < 80) begin
                if ($urandom_range(0, 1) == 0) begin
                    // lead byte followed by junk
                    send_item(OP_BYTE, cfg_sync_lead);
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                end else begin
                    // truncated frame; whatever follows is taken as payload
                    len = 8'($urandom_range(2, 6));
                    cut = $urandom_range(0, len - 1);
                    send_item(OP_BYTE, cfg_sync_lead);
                    send_item(OP_BYTE, cfg_sync_trail);
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                    send_item(OP_BYTE, len);
                    repeat (cut) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                end
            end else if (r < 90) begin
                send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
            end else begin
                send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_phases();
        logic [7:0] shared;
        set_config(8'hAA, 8'h55, 8'd64);
        random_phase(110, 16);
        set_config(8'h00, 8'hFF, 8'd0);
        random_phase(110, 8);
        // largest capacity with one full-length frame
        set_config(8'hFF, 8'h00, 8'd255);
        send_frame(8'($urandom_range(0, 255)), 8'd255, 1'b0);
        send_item(OP_RELEASE, 8'h00);
        random_phase(100, 20);
        // no idling on either side
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(1, 8)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_phase(110, 12);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 20)));
        random_phase(110, 24);
        // both sync bytes equal
        shared = 8'($urandom_range(0, 255));
        set_config(shared, shared, 8'd4);
        random_phase(80, 8);
    endtask

    // Receiver pacing: random hold-off per result, plus the long hold on request
    initial begin : rx_pacing
        int gap;
        bit took;
        gap = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            took = o_out_valid && !i_out_stall;
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (hold_len - 1) @(negedge i_clk);
                hold_req = 1'b0;
                gap = 0;
            end else begin
                if (took) gap = rx_idle_on ? $urandom_range(0, 3) : 0;
                if (gap > 0) begin
                    i_out_stall = 1'b1;
                    gap--;
                end else begin
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    task automatic note_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10)
                $display("result %0d: %s expected %0d, got %0d", result_count, name, want, got);
        end
    endtask

    // Compare every result transfer with the oldest expectation
    initial begin : result_check
        t_deframe_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) $display("result %0d: none expected", result_count);
                end else begin
                    want = expected_results.pop_front();
                    note_field("store_valid", 8'(want.store_valid), 8'(o_store_valid));
                    note_field("store_index", want.store_index, o_store_index);
                    note_field("store_data", want.store_data, o_store_data);
                    note_field("frame_done", 8'(want.frame_done), 8'(o_frame_done));
                    note_field("frame_address", want.frame_address, o_frame_address);
                    note_field("frame_length", want.frame_length, o_frame_length);
                    note_field("frame_too_long", 8'(want.frame_too_long),
                               8'(o_frame_too_long));
                    note_field("byte_dropped_busy", 8'(want.byte_dropped_busy),
                               8'(o_byte_dropped_busy));
                end
                result_count++;
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SYNC_FIRST;
        i_cfg_data = 8'd0;
        i_in_valid = 1'b0;
        i_op = OP_BYTE;
        i_rx_byte = 8'd0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req = 1'b0;
        hold_len = 0;
        error_count = 0;
        result_count = 0;
        sent_count = 0;
        cfg_sync_lead = RST_SYNC_FIRST;
        cfg_sync_trail = RST_SYNC_SECOND;
        cfg_capacity = RST_SLOT_CAPACITY;
        hunt_phase = PH_SYNC0;
        frame_addr_q = 8'd0;
        frame_len_q = 8'd0;
        byte_pos = 8'd0;
        slot_full = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_frame();
        test_special_cases();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: serial_frame_receive_deframer.f
+incdir+rtl/core
rtl/core/sfrd_pkg.sv
rtl/core/serial_frame_receive_deframer.sv
tb/serial_frame_receive_deframer_tb.sv
